[sv/thruster_kill_interlock_unit_defines.svh]
// Assertion macros shared by the interlock checker
`ifndef THRUSTER_KILL_INTERLOCK_UNIT_DEFINES_SVH
`define THRUSTER_KILL_INTERLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define TKI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("interlock check failed");

// Next-cycle implication, disabled while reset is held
`define TKI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("interlock check failed");

`endif

[sv/tki_pkg.sv]
// Types, codes and helper functions of the thruster kill interlock
package tki_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned SourceW = 2;
  localparam int unsigned ModeW   = 8;
  localparam int unsigned TargetW = 8;
  localparam int unsigned RawW    = 16;
  localparam int unsigned SpeedW  = 11;
  localparam int unsigned KillW   = 6;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Item kinds
  typedef enum logic [KindW-1:0] {
    KIND_SOFT_KILL = 3'd0,
    KIND_LINK      = 3'd1,
    KIND_RC_THRUST = 3'd2,
    KIND_PC_THRUST = 3'd3,
    KIND_HARD_KILL = 3'd4,
    KIND_ESC_CTRL  = 3'd5,
    KIND_TICK      = 3'd6
  } kind_e;

  // Light-tower states
  typedef enum logic [1:0] {
    LAMP_AUTO    = 2'd0,
    LAMP_RC      = 2'd1,
    LAMP_KILLED  = 2'd2,
    LAMP_STATION = 2'd3
  } lamp_e;

  // ESC commands
  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_KILL   = 2'd1,
    ESC_UNKILL = 2'd2
  } esc_cmd_e;

  // Control modes
  localparam logic [ModeW-1:0] MODE_AUTO    = 8'd1;
  localparam logic [ModeW-1:0] MODE_RC      = 8'd2;
  localparam logic [ModeW-1:0] MODE_STATION = 8'd3;

  // Soft-kill sources and ESC targets
  localparam logic [SourceW-1:0] SRC_SBC = 2'd0;
  localparam logic [SourceW-1:0] SRC_RC  = 2'd1;
  localparam logic [TargetW-1:0] SEL_ESC1 = 8'd1;
  localparam logic [TargetW-1:0] SEL_ESC2 = 8'd2;

  // Kill-reason bit positions
  localparam int unsigned BIT_HARD  = 0;
  localparam int unsigned BIT_SBC   = 1;
  localparam int unsigned BIT_RC    = 2;
  localparam int unsigned BIT_TELEM = 3;
  localparam int unsigned BIT_ESC1  = 4;
  localparam int unsigned BIT_ESC2  = 5;

  localparam logic [KillW-1:0] KILL_RESET = 6'b001111;
  localparam logic [1:0]       ESC_OFF_ALL = 2'b11;
  localparam logic [PeriodW-1:0] BLINK_RESET = 16'd500;

  // Lamp pin codes
  localparam logic [2:0] PIN_GREEN  = 3'b001;
  localparam logic [2:0] PIN_YELLOW = 3'b010;
  localparam logic [2:0] PIN_RED    = 3'b100;
  localparam logic [2:0] PIN_NONE   = 3'b000;

  // Register index (byte address bit 2)
  localparam logic REG_BLINK_PERIOD = 1'b0;

  localparam logic signed [SpeedW-1:0] SPEED_MAX = 11'sd1000;

  // Scale a raw command: floor(raw*5/16) - 1000, clamped to +1000
  function automatic logic signed [SpeedW-1:0] scale_speed(input logic [RawW-1:0] raw);
    logic [RawW+2:0]  prod;
    logic [RawW-2:0]  quot;
    logic signed [RawW:0] v;
    prod = ({3'b000, raw} << 2) + {3'b000, raw};
    quot = prod[RawW+2:4];
    v    = $signed({2'b00, quot}) - 17'sd1000;
    if (v > 17'sd1000) begin
      return SPEED_MAX;
    end
    return v[SpeedW-1:0];
  endfunction

endpackage

[sv/tki_item_if.sv]
// Input channel: one decoded bus message or time tick per transaction
interface tki_item_if;
  logic                          valid;
  logic                          ready;
  logic [tki_pkg::KindW-1:0]     kind;
  logic                          kill_request;
  logic [tki_pkg::SourceW-1:0]   kill_source;
  logic [tki_pkg::ModeW-1:0]     mode_value;
  logic [tki_pkg::TargetW-1:0]   esc_select;
  logic [tki_pkg::RawW-1:0]      raw_speed_0;
  logic [tki_pkg::RawW-1:0]      raw_speed_1;
  logic [tki_pkg::RawW-1:0]      raw_speed_2;
  logic [tki_pkg::RawW-1:0]      raw_speed_3;

  modport source (
    output valid, kind, kill_request, kill_source, mode_value, esc_select,
           raw_speed_0, raw_speed_1, raw_speed_2, raw_speed_3,
    input  ready
  );
  modport sink (
    input  valid, kind, kill_request, kill_source, mode_value, esc_select,
           raw_speed_0, raw_speed_1, raw_speed_2, raw_speed_3,
    output ready
  );
endinterface

[sv/tki_result_if.sv]
// Result channel: speeds, ESC commands, kill reasons and lamp drive
interface tki_result_if;
  logic                              valid;
  logic                              ready;
  logic                              speed_valid;
  logic signed [tki_pkg::SpeedW-1:0] speed_0;
  logic signed [tki_pkg::SpeedW-1:0] speed_1;
  logic signed [tki_pkg::SpeedW-1:0] speed_2;
  logic signed [tki_pkg::SpeedW-1:0] speed_3;
  logic [1:0]                        esc1_command;
  logic [1:0]                        esc2_command;
  logic [tki_pkg::KillW-1:0]         kill_reason_bits;
  logic [1:0]                        lamp_state;
  logic [2:0]                        lamp_pins;

  modport source (
    output valid, speed_valid, speed_0, speed_1, speed_2, speed_3,
           esc1_command, esc2_command, kill_reason_bits, lamp_state, lamp_pins,
    input  ready
  );
  modport sink (
    input  valid, speed_valid, speed_0, speed_1, speed_2, speed_3,
           esc1_command, esc2_command, kill_reason_bits, lamp_state, lamp_pins,
    output ready
  );
endinterface

[sv/thruster_kill_interlock_unit.sv]
// An accepted transaction shows its registered result from the following cycle on.
// Throughput: one transaction per cycle; the single result register is the only stage.
// The input is taken whenever the result register is empty or is being drained.
// Reset (rst_ni low, asynchronous): all kill reasons but the ESC bits set, both ESCs
// killed, tower killed, mode 0, blink timer cleared, blink period 500, no result held.
module thruster_kill_interlock_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tki_item_if.sink                        item_i,
  tki_result_if.source                    result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tki_pkg::ApbAddrW-1:0]    paddr,
  input  logic [tki_pkg::ApbDataW-1:0]    pwdata,
  output logic [tki_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  // State
  logic [tki_pkg::KillW-1:0]   kill_q, kill_d;
  logic [tki_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [1:0]                  esc_off_q, esc_off_d;
  tki_pkg::lamp_e              tower_q, tower_d;
  logic                        blink_on_q, blink_on_d;
  logic [tki_pkg::PeriodW-1:0] ticks_q, ticks_d, ticks_inc;
  logic [tki_pkg::PeriodW-1:0] period_q;

  // Result register
  logic                              out_valid_q;
  logic                              spd_valid_q, spd_valid_d;
  logic signed [tki_pkg::SpeedW-1:0] spd0_q, spd1_q, spd2_q, spd3_q;
  tki_pkg::esc_cmd_e                 cmd1_q, cmd1_d, cmd2_q, cmd2_d;
  logic [2:0]                        pins_q, pins_d;

  logic            accept;
  logic            cfg_wr;
  tki_pkg::kind_e  kind;

  assign kind   = tki_pkg::kind_e'(item_i.kind);
  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept = item_i.valid && item_i.ready;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == tki_pkg::REG_BLINK_PERIOD)
                  ? {{(tki_pkg::ApbDataW-tki_pkg::PeriodW){1'b0}}, period_q}
                  : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= tki_pkg::BLINK_RESET;
    end else if (cfg_wr && paddr[2] == tki_pkg::REG_BLINK_PERIOD) begin
      period_q <= pwdata[tki_pkg::PeriodW-1:0];
    end
  end

  // Apply the message to the kill reasons, the mode and the speed-valid flag
  always_comb begin
    kill_d      = kill_q;
    mode_d      = mode_q;
    spd_valid_d = 1'b0;
    unique case (kind)
      tki_pkg::KIND_SOFT_KILL: begin
        if (item_i.kill_source == tki_pkg::SRC_SBC) begin
          if (mode_q != tki_pkg::MODE_RC) begin
            kill_d[tki_pkg::BIT_SBC] = item_i.kill_request;
          end
        end else if (item_i.kill_source == tki_pkg::SRC_RC) begin
          kill_d[tki_pkg::BIT_RC] = item_i.kill_request;
        end
      end
      tki_pkg::KIND_LINK: begin
        mode_d = item_i.mode_value;
        if (item_i.mode_value == tki_pkg::MODE_RC) begin
          kill_d[tki_pkg::BIT_SBC] = 1'b0;
        end
      end
      tki_pkg::KIND_RC_THRUST: begin
        spd_valid_d = (mode_q == tki_pkg::MODE_RC);
        kill_d[tki_pkg::BIT_TELEM] = 1'b0;
      end
      tki_pkg::KIND_PC_THRUST: begin
        spd_valid_d = (mode_q == tki_pkg::MODE_AUTO) || (mode_q == tki_pkg::MODE_STATION);
      end
      tki_pkg::KIND_HARD_KILL: begin
        kill_d[tki_pkg::BIT_HARD] = item_i.kill_request;
      end
      tki_pkg::KIND_ESC_CTRL: begin
        if (item_i.esc_select == tki_pkg::SEL_ESC1) begin
          kill_d[tki_pkg::BIT_ESC1] = item_i.kill_request;
        end else if (item_i.esc_select == tki_pkg::SEL_ESC2) begin
          kill_d[tki_pkg::BIT_ESC2] = item_i.kill_request;
        end
      end
      default: begin
      end
    endcase
  end

  // Evaluate the kill logic and the tower state
  always_comb begin
    tower_d = tower_q;
    if (|kill_d[tki_pkg::BIT_TELEM:tki_pkg::BIT_HARD]) begin
      esc_off_d = tki_pkg::ESC_OFF_ALL;
      tower_d   = tki_pkg::LAMP_KILLED;
    end else begin
      esc_off_d = {kill_d[tki_pkg::BIT_ESC2], kill_d[tki_pkg::BIT_ESC1]};
      case (mode_d)
        tki_pkg::MODE_AUTO:    tower_d = tki_pkg::LAMP_AUTO;
        tki_pkg::MODE_STATION: tower_d = tki_pkg::LAMP_STATION;
        tki_pkg::MODE_RC:      tower_d = tki_pkg::LAMP_RC;
        default:               tower_d = tower_q;
      endcase
    end
  end

  // Issue a command on each change of an ESC flag
  always_comb begin
    cmd1_d = tki_pkg::ESC_NONE;
    cmd2_d = tki_pkg::ESC_NONE;
    if (esc_off_d[0] != esc_off_q[0]) begin
      cmd1_d = esc_off_d[0] ? tki_pkg::ESC_KILL : tki_pkg::ESC_UNKILL;
    end
    if (esc_off_d[1] != esc_off_q[1]) begin
      cmd2_d = esc_off_d[1] ? tki_pkg::ESC_KILL : tki_pkg::ESC_UNKILL;
    end
  end

  // Drive lamps from the new tower state; the station lamp blinks with the phase held before this transaction
  always_comb begin
    case (tower_d)
      tki_pkg::LAMP_AUTO:    pins_d = tki_pkg::PIN_GREEN;
      tki_pkg::LAMP_RC:      pins_d = tki_pkg::PIN_YELLOW;
      tki_pkg::LAMP_KILLED:  pins_d = tki_pkg::PIN_RED;
      default:               pins_d = blink_on_q ? tki_pkg::PIN_YELLOW : tki_pkg::PIN_NONE;
    endcase
  end

  // Advance the blink timer on a tick
  assign ticks_inc = ticks_q + 1'b1;
  always_comb begin
    ticks_d    = ticks_q;
    blink_on_d = blink_on_q;
    if (kind == tki_pkg::KIND_TICK) begin
      if (ticks_inc >= period_q) begin
        blink_on_d = !blink_on_q;
        ticks_d    = '0;
      end else begin
        ticks_d = ticks_inc;
      end
    end
  end

  // Commit state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_q     <= tki_pkg::KILL_RESET;
      mode_q     <= '0;
      esc_off_q  <= tki_pkg::ESC_OFF_ALL;
      tower_q    <= tki_pkg::LAMP_KILLED;
      blink_on_q <= 1'b0;
      ticks_q    <= '0;
    end else if (accept) begin
      kill_q     <= kill_d;
      mode_q     <= mode_d;
      esc_off_q  <= esc_off_d;
      tower_q    <= tower_d;
      blink_on_q <= blink_on_d;
      ticks_q    <= ticks_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      spd_valid_q <= spd_valid_d;
      spd0_q <= spd_valid_d ? tki_pkg::scale_speed(item_i.raw_speed_0) : '0;
      spd1_q <= spd_valid_d ? tki_pkg::scale_speed(item_i.raw_speed_1) : '0;
      spd2_q <= spd_valid_d ? tki_pkg::scale_speed(item_i.raw_speed_2) : '0;
      spd3_q <= spd_valid_d ? tki_pkg::scale_speed(item_i.raw_speed_3) : '0;
      cmd1_q <= cmd1_d;
      cmd2_q <= cmd2_d;
      pins_q <= pins_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.speed_valid      = spd_valid_q;
  assign result_o.speed_0          = spd0_q;
  assign result_o.speed_1          = spd1_q;
  assign result_o.speed_2          = spd2_q;
  assign result_o.speed_3          = spd3_q;
  assign result_o.esc1_command     = cmd1_q;
  assign result_o.esc2_command     = cmd2_q;
  assign result_o.kill_reason_bits = kill_q;
  assign result_o.lamp_state       = tower_q;
  assign result_o.lamp_pins        = pins_q;

endmodule

[sv/tki_checker.sv]
// Port-level checks of the interlock, bound to the top level
`include "thruster_kill_interlock_unit_defines.svh"

module tki_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              speed_valid,
  input logic signed [tki_pkg::SpeedW-1:0] speed_0,
  input logic signed [tki_pkg::SpeedW-1:0] speed_1,
  input logic signed [tki_pkg::SpeedW-1:0] speed_2,
  input logic signed [tki_pkg::SpeedW-1:0] speed_3,
  input logic [1:0]                        esc1_command,
  input logic [tki_pkg::KillW-1:0]         kill_reason_bits,
  input logic [1:0]                        lamp_state,
  input logic [2:0]                        lamp_pins
);

  // Every accepted transaction leaves a result behind it
  `TKI_ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid)

  // A pending result is not dropped before it is taken
  `TKI_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

  // Speeds read zero unless a thrust frame was taken
  `TKI_ASSERT_NOW(a_speed_zero, out_valid && !speed_valid,
                  speed_0 == '0 && speed_1 == '0 && speed_2 == '0 && speed_3 == '0)

  // Any true hard, SBC, RC or telemetry kill reason shows the tower killed with only the red lamp
  `TKI_ASSERT_NOW(a_killed_lamp, out_valid && (|kill_reason_bits[3:0]),
                  lamp_state == tki_pkg::LAMP_KILLED && lamp_pins == tki_pkg::PIN_RED)

  // A kill command for ESC1 needs a reason that covers ESC1
  `TKI_ASSERT_NOW(a_esc1_kill_reason, out_valid && esc1_command == tki_pkg::ESC_KILL,
                  (|kill_reason_bits[3:0]) || kill_reason_bits[tki_pkg::BIT_ESC1])

endmodule

bind thruster_kill_interlock_unit tki_checker u_tki_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid         (item_i.valid),
  .in_ready         (item_i.ready),
  .out_valid        (result_o.valid),
  .out_ready        (result_o.ready),
  .speed_valid      (result_o.speed_valid),
  .speed_0          (result_o.speed_0),
  .speed_1          (result_o.speed_1),
  .speed_2          (result_o.speed_2),
  .speed_3          (result_o.speed_3),
  .esc1_command     (result_o.esc1_command),
  .kill_reason_bits (result_o.kill_reason_bits),
  .lamp_state       (result_o.lamp_state),
  .lamp_pins        (result_o.lamp_pins)
);
